@@ rtl/is_pkg.sv @@
// Shared types and sequencer state codes for the insertion sorter.
// No dependencies.
`default_nettype none

package is_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

	localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an item
	localparam logic [1:0] ST_SCAN  = 2'd1;  // compare and shift entries toward the top
	localparam logic [1:0] ST_PLACE = 2'd2;  // write the new item at entry zero
	localparam logic [1:0] ST_EMIT  = 2'd3;  // read the batch out in ascending order

endpackage

`default_nettype wire

@@ rtl/is_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module is_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/insertion_sorter_top.sv @@
// Insertion sorter top level; uses is_pkg and is_ram (store of CAPACITY words).
// Input: an item into an empty or full store is taken in ST_IDLE; otherwise the top
// entry is read and ST_SCAN shifts entries up (at most fill count) until the item lands,
// ST_PLACE writing it at entry zero if all moved; paced by the one-read, one-write port.
// Output: after the marked item, each result is read, then loaded; reads do not overlap.
// Reset: fill count, drop flag and handshakes clear at once; no clearing pass.
`default_nettype none

module insertion_sorter_top #(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire is_pkg::data_t value,
	input  wire logic          batch_end,
	output logic               out_valid,
	input  wire logic          out_ready,
	output is_pkg::data_t      sorted_value,
	output logic               final_out,
	output logic               overflowed
);

	import is_pkg::*;

	localparam int AW = $clog2(CAPACITY);      // store address
	localparam int CW = $clog2(CAPACITY + 1);  // fill count, 0..CAPACITY

	// control state
	logic [1:0]    state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic          drop_q, drop_d;
	logic [AW-1:0] pos_q, pos_d;           // entry that the next shift writes
	logic [CW-1:0] k_q, k_d;               // next entry to read out
	logic          rd_pend_q, rd_pend_d;   // read-out data arrives this cycle
	logic          fin_pend_q, fin_pend_d; // ... and it is the batch's last
	logic          out_valid_q, out_valid_d;

	// payload
	data_t         val_q;
	logic          last_q;
	data_t         sorted_value_q;
	logic          final_q;
	logic          ovf_q;

	logic          in_acc;
	logic          load_in;
	logic          load_out;
	logic          not_full;
	data_t         rd_val;

	// store port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	is_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign not_full = (fill_q < CW'(CAPACITY));
	assign rd_val   = data_t'(ram_rdata);

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		drop_d     = drop_q;
		pos_d      = pos_q;
		k_d        = k_q;
		rd_pend_d  = 1'b0;
		fin_pend_d = fin_pend_q;
		load_in    = 1'b0;
		load_out   = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = pos_q;
		ram_wdata  = DATA_W'(val_q);
		ram_re     = 1'b0;
		ram_raddr  = '0;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					load_in = 1'b1;
					k_d     = '0;
					if (!not_full) begin
						// store full: item is dropped, batch may still end
						drop_d  = 1'b1;
						state_d = batch_end ? ST_EMIT : ST_IDLE;
					end else if (fill_q == '0) begin
						ram_we    = 1'b1;
						ram_waddr = '0;
						ram_wdata = DATA_W'(value);
						fill_d    = fill_q + 1'b1;
						state_d   = batch_end ? ST_EMIT : ST_IDLE;
					end else begin
						// fetch the top entry; the new item starts above it
						ram_re    = 1'b1;
						ram_raddr = AW'(fill_q - 1'b1);
						pos_d     = AW'(fill_q);
						state_d   = ST_SCAN;
					end
				end
			end

			ST_SCAN: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				if (rd_val < val_q) begin
					// entry below is smaller: the item lands here
					ram_wdata = DATA_W'(val_q);
					fill_d    = fill_q + 1'b1;
					state_d   = last_q ? ST_EMIT : ST_IDLE;
				end else begin
					// move the entry up one place; the next entry is already on its way
					ram_wdata = ram_rdata;
					if (pos_q == AW'(1)) begin
						state_d = ST_PLACE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = pos_q - 1'b1 - 1'b1;
						pos_d     = pos_q - 1'b1;
					end
				end
			end

			ST_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = DATA_W'(val_q);
				fill_d    = fill_q + 1'b1;
				state_d   = last_q ? ST_EMIT : ST_IDLE;
			end

			ST_EMIT: begin
				// issue a read only when the output register is free by next cycle
				if ((k_q != fill_q) && !rd_pend_q && (!out_valid_q || out_ready)) begin
					ram_re     = 1'b1;
					ram_raddr  = AW'(k_q);
					k_d        = k_q + 1'b1;
					rd_pend_d  = 1'b1;
					fin_pend_d = ((k_q + 1'b1) == fill_q);
				end
				if (rd_pend_q) begin
					load_out = 1'b1;
					if (fin_pend_q) begin
						// last result is loaded; new batch starts empty
						state_d = ST_IDLE;
						fill_d  = '0;
						drop_d  = 1'b0;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			drop_q      <= 1'b0;
			pos_q       <= '0;
			k_q         <= '0;
			rd_pend_q   <= 1'b0;
			fin_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			drop_q      <= drop_d;
			pos_q       <= pos_d;
			k_q         <= k_d;
			rd_pend_q   <= rd_pend_d;
			fin_pend_q  <= fin_pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_in) begin
			val_q  <= value;
			last_q <= batch_end;
		end
		if (load_out) begin
			sorted_value_q <= rd_val;
			final_q        <= fin_pend_q;
			ovf_q          <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign final_out    = final_q;
	assign overflowed   = ovf_q;

`ifndef NO_ASSERTIONS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("store read and write hit the same entry");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> (!out_valid_q || out_ready))
		else $error("read-out data would overwrite a waiting result");

	a_batch_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_q && fin_pend_q) |=> ((fill_q == '0) && !drop_q && out_valid_q))
		else $error("batch state not cleared after final result");
`endif

endmodule

`default_nettype wire
